### sv/usbcdc_pkg.sv
`default_nettype none
package usbcdc_pkg;

  localparam logic [7:0] TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
  localparam logic [1:0] XFER_BULK      = 2'b10;
  localparam int unsigned DIR_IN_BIT    = 7;
  localparam logic [7:0] CLASS_CDC_DATA = 8'h0A;

  localparam logic [7:0] OFF_LENGTH = 8'd0;
  localparam logic [7:0] OFF_TYPE   = 8'd1;
  localparam logic [7:0] OFF_FIELD  = 8'd2;
  localparam logic [7:0] OFF_ATTR   = 8'd3;
  localparam logic [7:0] OFF_CLASS  = 8'd5;

  typedef struct packed {
    logic       found;
    logic [7:0] interface_number;
    logic [7:0] bulk_in_endpoint;
    logic [7:0] bulk_out_endpoint;
  } usbcdc_result_t;

endpackage
`default_nettype wire

### sv/usbcdc_walk.sv
`default_nettype none
module usbcdc_walk
  import usbcdc_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_write_en,
  input  wire logic [7:0]     cfg_write_data,
  input  wire logic           beat_en,
  input  wire logic [7:0]     desc_byte,
  input  wire logic           last_byte,
  output      logic           emit,
  output      usbcdc_result_t result
);

  logic [7:0] wanted_class_r;
  logic [7:0] offset_r, offset_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] held_r, held_nxt;
  logic       inside_r, inside_nxt;
  logic       finished_r, finished_nxt;
  logic [7:0] match_r, match_nxt;
  logic [7:0] in_addr_r, in_addr_nxt;
  logic [7:0] out_addr_r, out_addr_nxt;

  logic       both;
  logic       emit_early;
  logic       ok_early;
  logic [8:0] off_inc;

  always_comb begin
    offset_nxt   = offset_r;
    length_nxt   = length_r;
    type_nxt     = type_r;
    held_nxt     = held_r;
    inside_nxt   = inside_r;
    finished_nxt = finished_r;
    match_nxt    = match_r;
    in_addr_nxt  = in_addr_r;
    out_addr_nxt = out_addr_r;
    both         = (in_addr_r != 8'd0) && (out_addr_r != 8'd0);
    emit_early   = 1'b0;
    ok_early     = 1'b0;
    off_inc      = {1'b0, offset_r} + 9'd1;

    if (!finished_r) begin
      if (offset_r == OFF_LENGTH && desc_byte == 8'd0) begin
        emit_early = 1'b1;
        ok_early   = inside_r && both;
      end else begin
        priority if (offset_r == OFF_LENGTH) begin
          length_nxt = desc_byte;
          type_nxt   = 8'd0;
        end else if (offset_r == OFF_TYPE) begin
          type_nxt = desc_byte;
          if (desc_byte == TYPE_INTERFACE && inside_r) begin
            if (both) begin
              emit_early = 1'b1;
              ok_early   = 1'b1;
            end else begin
              inside_nxt = 1'b0;
            end
          end
        end else if (offset_r == OFF_FIELD) begin
          held_nxt = desc_byte;
        end else if (offset_r == OFF_ATTR) begin
          if (type_r == TYPE_ENDPOINT && inside_r && desc_byte[1:0] == XFER_BULK) begin
            if (held_r[DIR_IN_BIT]) begin
              in_addr_nxt = held_r;
            end else begin
              out_addr_nxt = held_r;
            end
          end
        end else if (offset_r == OFF_CLASS) begin
          if (type_r == TYPE_INTERFACE && desc_byte == wanted_class_r) begin
            inside_nxt = 1'b1;
            match_nxt  = held_r;
          end
        end else begin
          held_nxt = held_r;
        end
        if (off_inc >= {1'b0, length_nxt}) begin
          offset_nxt = 8'd0;
        end else begin
          offset_nxt = off_inc[7:0];
        end
      end
      finished_nxt = emit_early;
    end

    emit = !finished_r && (emit_early || last_byte);
    result.found = emit_early ? ok_early
                 : (inside_nxt && in_addr_nxt != 8'd0 && out_addr_nxt != 8'd0);
    result.interface_number  = match_nxt;
    result.bulk_in_endpoint  = in_addr_nxt;
    result.bulk_out_endpoint = out_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_class_r <= CLASS_CDC_DATA;
    end else if (cfg_write_en) begin
      wanted_class_r <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (beat_en && last_byte)) begin
      offset_r   <= 8'd0;
      length_r   <= 8'd0;
      type_r     <= 8'd0;
      held_r     <= 8'd0;
      inside_r   <= 1'b0;
      finished_r <= 1'b0;
      match_r    <= 8'd0;
      in_addr_r  <= 8'd0;
      out_addr_r <= 8'd0;
    end else if (beat_en) begin
      offset_r   <= offset_nxt;
      length_r   <= length_nxt;
      type_r     <= type_nxt;
      held_r     <= held_nxt;
      inside_r   <= inside_nxt;
      finished_r <= finished_nxt;
      match_r    <= match_nxt;
      in_addr_r  <= in_addr_nxt;
      out_addr_r <= out_addr_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/usb_cdc_descriptor_scanner.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_desc_byte, in_last_byte
// out      output     out_valid / out_ready  out_found, out_interface_number,
//                                            out_bulk_in_endpoint, out_bulk_out_endpoint
// cfg      input      cfg_write_en           cfg_write_data (wanted class)
//
// one descriptor byte per cycle while in_ready is high; a result shows in the cycle
// after the beat that ends the search, held in a single output register
// in_ready is high whenever the output register is empty or being drained
// rst_n is synchronous; wanted class returns to 0x0A, the walk state clears
`default_nettype none
module usb_cdc_descriptor_scanner
  import usbcdc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_write_en,
  input  wire logic [7:0] cfg_write_data,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] in_desc_byte,
  input  wire logic       in_last_byte,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic       out_found,
  output      logic [7:0] out_interface_number,
  output      logic [7:0] out_bulk_in_endpoint,
  output      logic [7:0] out_bulk_out_endpoint
);

  logic           beat_en;
  logic           emit;
  usbcdc_result_t result;
  usbcdc_result_t result_r;
  logic           out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign beat_en  = in_valid && in_ready;

  usbcdc_walk u_walk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .beat_en        (beat_en),
    .desc_byte      (in_desc_byte),
    .last_byte      (in_last_byte),
    .emit           (emit),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= beat_en && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_en && emit) begin
      result_r <= result;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_found             = result_r.found;
  assign out_interface_number  = result_r.interface_number;
  assign out_bulk_in_endpoint  = result_r.bulk_in_endpoint;
  assign out_bulk_out_endpoint = result_r.bulk_out_endpoint;

endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb
  import usbcdc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] TYPE_CONFIG       = 8'h02;
  localparam logic [7:0] TYPE_CS_INTERFACE = 8'h24;
  localparam int         NUM_PHASES        = 7;
  localparam int         BEATS_PER_PHASE   = 180;
  localparam int         HOLD_CYCLES       = 400;

  class scan_tracker;
    logic [7:0]     class_sel;
    logic [7:0]     pos;
    logic [7:0]     desc_len;
    logic [7:0]     desc_type;
    logic [7:0]     field_hold;
    logic [7:0]     iface_num;
    logic [7:0]     ep_in;
    logic [7:0]     ep_out;
    logic           matching;
    logic           done;
    usbcdc_result_t expected_results[$];
    int             mismatches;

    function new();
      class_sel  = CLASS_CDC_DATA;
      mismatches = 0;
      clear_walk();
    endfunction

    function void clear_walk();
      pos        = '0;
      desc_len   = '0;
      desc_type  = '0;
      field_hold = '0;
      iface_num  = '0;
      ep_in      = '0;
      ep_out     = '0;
      matching   = 1'b0;
      done       = 1'b0;
    endfunction

    function void post_result(logic ok);
      usbcdc_result_t r;
      r.found             = ok;
      r.interface_number  = iface_num;
      r.bulk_in_endpoint  = ep_in;
      r.bulk_out_endpoint = ep_out;
      expected_results.push_back(r);
      done = 1'b1;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic both;
      if (!done) begin
        both = (ep_in != 0) && (ep_out != 0);
        if (pos == OFF_LENGTH && b == 8'h00) begin
          post_result(matching && both);
        end else begin
          case (pos)
            OFF_LENGTH: begin
              desc_len  = b;
              desc_type = '0;
            end
            OFF_TYPE: begin
              desc_type = b;
              if (b == TYPE_INTERFACE && matching) begin
                if (both) post_result(1'b1);
                else matching = 1'b0;
              end
            end
            OFF_FIELD: field_hold = b;
            OFF_ATTR: begin
              if (desc_type == TYPE_ENDPOINT && matching && b[1:0] == XFER_BULK) begin
                if (field_hold[DIR_IN_BIT]) ep_in = field_hold;
                else ep_out = field_hold;
              end
            end
            OFF_CLASS: begin
              if (desc_type == TYPE_INTERFACE && b == class_sel) begin
                matching  = 1'b1;
                iface_num = field_hold;
              end
            end
            default: ;
          endcase
          if (int'(pos) + 1 >= int'(desc_len)) pos = '0;
          else pos = pos + 8'd1;
        end
        if (last && !done) post_result(matching && (ep_in != 0) && (ep_out != 0));
      end
      if (last) clear_walk();
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(usbcdc_result_t got);
      usbcdc_result_t want;
      if (expected_results.size() == 0) begin
        report("result beat with no pending expectation");
      end else begin
        want = expected_results.pop_front();
        if (got.found !== want.found)
          report($sformatf("found %b, expected %b", got.found, want.found));
        if (got.interface_number !== want.interface_number)
          report($sformatf("interface_number %h, expected %h",
                           got.interface_number, want.interface_number));
        if (got.bulk_in_endpoint !== want.bulk_in_endpoint)
          report($sformatf("bulk_in_endpoint %h, expected %h",
                           got.bulk_in_endpoint, want.bulk_in_endpoint));
        if (got.bulk_out_endpoint !== want.bulk_out_endpoint)
          report($sformatf("bulk_out_endpoint %h, expected %h",
                           got.bulk_out_endpoint, want.bulk_out_endpoint));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_write_en;
  logic [7:0] cfg_write_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_desc_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_found;
  logic [7:0] out_interface_number;
  logic [7:0] out_bulk_in_endpoint;
  logic [7:0] out_bulk_out_endpoint;

  scan_tracker tracker = new();
  logic [7:0]  blk[$];
  logic [7:0]  class_plan [NUM_PHASES] = '{8'h0A, 8'h00, 8'hFF, 8'h02, 8'h00, 8'h00, 8'h0A};
  int          beats;
  int          in_gap_pct;
  int          out_stall_pct;
  int          stall_left;
  logic        hold_req;
  logic        hold_on;

  usb_cdc_descriptor_scanner i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_write_en         (cfg_write_en),
    .cfg_write_data       (cfg_write_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_desc_byte         (in_desc_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_found            (out_found),
    .out_interface_number (out_interface_number),
    .out_bulk_in_endpoint (out_bulk_in_endpoint),
    .out_bulk_out_endpoint(out_bulk_out_endpoint)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(13, 50);
  endfunction

  function automatic logic [7:0] pick_class();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return tracker.class_sel;
    if (r < 65) return CLASS_CDC_DATA;
    if (r < 80) return 8'h02;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_desc(int len, logic [7:0] typ, logic [7:0] f2, logic [7:0] f3,
                                   logic [7:0] f5);
    blk.push_back(8'(len));
    for (int k = 1; k < len; k++) begin
      case (k)
        1: blk.push_back(typ);
        2: blk.push_back(f2);
        3: blk.push_back(f3);
        5: blk.push_back(f5);
        default: blk.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic void build_block();
    int         len;
    int         cut;
    logic [7:0] addr;
    logic [7:0] attr;
    logic [7:0] num;
    blk.delete();
    // noise block
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 30)) blk.push_back(8'($urandom_range(0, 255)));
      return;
    end
    add_desc(9, TYPE_CONFIG, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
    repeat ($urandom_range(1, 4)) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : 9;
      num = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
      add_desc(len, TYPE_INTERFACE, num, 8'($urandom_range(0, 255)), pick_class());
      repeat ($urandom_range(0, 2))
        add_desc($urandom_range(3, 8), TYPE_CS_INTERFACE, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 7;
        if ($urandom_range(0, 9) == 0) addr = 8'($urandom_range(0, 255));
        else addr = {1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(0, 15))};
        if ($urandom_range(0, 3) != 0) attr = {6'($urandom_range(0, 63)), XFER_BULK};
        else attr = 8'($urandom_range(0, 255));
        add_desc(len, TYPE_ENDPOINT, addr, attr, 8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      blk.push_back(8'h00);
      repeat ($urandom_range(0, 4)) blk.push_back(8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 19) == 0) begin
      cut = $urandom_range(1, blk.size() - 1);
      while (blk.size() > cut) void'(blk.pop_back());
    end
  endfunction

  task automatic send_beat(logic [7:0] b, logic last);
    int gap;
    gap = ($urandom_range(0, 99) < in_gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_desc_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(b, last);
    beats++;
  endtask

  task automatic send_block();
    for (int k = 0; k < blk.size(); k++) send_beat(blk[k], k == blk.size() - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_class(logic [7:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    tracker.class_sel = v;
    cfg_write_en <= 1'b0;
  endtask

  // result side: random stalls plus the long hold
  always @(posedge clk) begin
    usbcdc_result_t got;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.found             = out_found;
        got.interface_number  = out_interface_number;
        got.bulk_in_endpoint  = out_bulk_in_endpoint;
        got.bulk_out_endpoint = out_bulk_out_endpoint;
        tracker.check_result(got);
      end
      if (hold_on) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < out_stall_pct) stall_left = pick_gap();
      end
    end
  end

  initial begin
    hold_on <= 1'b0;
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= 8'h00;
    in_valid       <= 1'b0;
    in_desc_byte   <= 8'h00;
    in_last_byte   <= 1'b0;
    hold_req       <= 1'b0;
    out_stall_pct  <= 0;
    in_gap_pct     = 0;
    beats          = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // matching interface, both bulk endpoints, next interface closes the search
    blk = '{8'h06, 8'h04, 8'h05, 8'h00, 8'h00, 8'h0A, 8'h04, 8'h05, 8'h81, 8'h02,
            8'h04, 8'h05, 8'h02, 8'h06, 8'h09, 8'h04, 8'hFF};
    send_block();
    // zero length, then an ignored byte
    blk = '{8'h00, 8'hAA};
    send_block();
    // last byte alone
    blk = '{8'hFF};
    send_block();
    // length one descriptor, zero length on the last byte
    blk = '{8'h01, 8'h00};
    send_block();
    // short endpoint, never captured
    blk = '{8'h03, 8'h05, 8'h81, 8'h00};
    send_block();

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p == 4 || p == 5) write_class(8'($urandom_range(0, 255)));
      else write_class(class_plan[p]);
      in_gap_pct = (p == 1 || p == 3 || p == 5) ? 25 : ((p == 6) ? 60 : 0);
      out_stall_pct <= (p == 2 || p == 3 || p == 6) ? 30 : ((p == 5) ? 5 : 0);
      if (p == 2) hold_req <= 1'b1;
      beats = 0;
      while (beats < BEATS_PER_PHASE) begin
        build_block();
        send_block();
      end
    end

    settle();
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
sv/usbcdc_pkg.sv
sv/usbcdc_walk.sv
sv/usb_cdc_descriptor_scanner.sv
tb/tb.sv
